### design/assert_macros.svh
// Assertion macros shared by the packer's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies an expression in the next.
`define BP_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) else $error(msg);

`endif

### design/bp128_pkg.sv
// Types and constants shared by the 128-value bit packer.
package bp128_pkg;

	localparam int LANE_COUNT      = 4;
	localparam int WORD_W          = 32;
	localparam int BW_W            = 6;
	localparam int POS_W           = 5;
	localparam int SHIFT_W         = 5;
	localparam int ITEMS_PER_BLOCK = 32;

	localparam logic [BW_W-1:0] FULL_WIDTH = BW_W'(WORD_W);

	// register index, taken from paddr[2]
	localparam logic REG_BIT_WIDTH = 1'b0;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [LANE_COUNT-1:0] lane_vec_t;

	// one classified request on its way from front to back
	typedef struct packed {
		lane_vec_t          val;    // lane values already masked to B bits
		logic [SHIFT_W-1:0] shift;  // bit offset inside the current word
		logic               emit;   // word completes with this request
		logic               spill;  // bits overflow into the next word
		logic               last;   // final request of a block
	} bp128_entry_t;

endpackage

### design/bp128_front.sv
// Front end: accepts requests, masks lanes and works out offset and word events.
module bp128_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bp128_pkg::BW_W-1:0]   bit_width,
	input  logic                         item_valid,
	input  bp128_pkg::lane_vec_t         lanes,
	input  logic                         q_full,
	output logic                         item_ready,
	output logic                         push,
	output bp128_pkg::bp128_entry_t      entry
);
	import bp128_pkg::*;

	logic [POS_W-1:0]        item_index_q;
	logic [BW_W-1:0]         b;
	word_t                   mask;
	logic [POS_W+BW_W-1:0]   prod;
	logic [BW_W:0]           fill;

	assign item_ready = !q_full;
	assign push       = item_valid && !q_full;

	always_comb begin
		// widths above 32 saturate
		b    = (bit_width > FULL_WIDTH) ? FULL_WIDTH : bit_width;
		mask = (b >= FULL_WIDTH) ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << b);
		prod = {{BW_W{1'b0}}, item_index_q} * {{POS_W{1'b0}}, b};
		entry.shift = prod[SHIFT_W-1:0];
		fill = {2'b00, entry.shift} + {1'b0, b};
		entry.emit  = (b != '0) && (fill >= (BW_W+1)'(WORD_W));
		entry.spill = (b != '0) && (fill > (BW_W+1)'(WORD_W));
		entry.last  = (item_index_q == POS_W'(ITEMS_PER_BLOCK - 1));
		for (int k = 0; k < LANE_COUNT; k++) begin
			entry.val[k] = lanes[k] & mask;
		end
	end

	// position wraps modulo the block length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_index_q <= '0;
		end else if (push) begin
			item_index_q <= item_index_q + 1'b1;
		end
	end

endmodule

### design/bp128_queue.sv
// Short queue of classified requests between front and back.
module bp128_queue #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  bp128_pkg::bp128_entry_t      push_entry,
	input  logic                         pop,
	output logic                         full,
	output logic                         empty,
	output bp128_pkg::bp128_entry_t      head
);
	import bp128_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bp128_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/bp128_back.sv
// Back end: per-lane accumulators and the output register.
module bp128_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  bp128_pkg::bp128_entry_t      head,
	input  logic                         word_ready,
	output logic                         pop,
	output logic                         word_valid,
	output bp128_pkg::lane_vec_t         words,
	output logic                         block_end
);
	import bp128_pkg::*;

	lane_vec_t  part_q;
	lane_vec_t  words_q;
	logic       block_end_q;
	logic       valid_q;
	lane_vec_t  acc;
	lane_vec_t  acc_next;
	logic       can_out;
	logic [BW_W-1:0] rshift;

	assign can_out    = !valid_q || word_ready;
	assign pop        = head_valid && (!head.emit || can_out);
	assign word_valid = valid_q;
	assign words      = words_q;
	assign block_end  = block_end_q;

	always_comb begin
		rshift = FULL_WIDTH - {1'b0, head.shift};
		for (int k = 0; k < LANE_COUNT; k++) begin
			acc[k] = (head.shift == '0) ? head.val[k]
				: (part_q[k] | (head.val[k] << head.shift));
			acc_next[k] = head.spill ? (head.val[k] >> rshift) : acc[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				part_q <= acc_next;
			end
			if (pop && head.emit) begin
				valid_q <= 1'b1;
			end else if (word_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			words_q     <= acc;
			block_end_q <= head.last;
		end
	end

endmodule

### design/bit_pack_128.sv
// A request is written into the queue first; its packed word is registered in the output register when it retires.
// Throughput: one request per cycle while the queue is not full; each lane's shift/OR is combinational.
// A 32-request block gives B words; the queue lets input run while output stalls.
// Reset (arst_n low, asynchronous): accumulators and block position clear, B = 32.
// No clearing pass; the block takes requests as soon as reset is released.
`include "assert_macros.svh"

module bit_pack_128 #(
	parameter int QUEUE_DEPTH = 4   // front/back decoupling queue, at least 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] lane_0,
	input  logic [31:0] lane_1,
	input  logic [31:0] lane_2,
	input  logic [31:0] lane_3,
	// packed word channel
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] word_lane_0,
	output logic [31:0] word_lane_1,
	output logic [31:0] word_lane_2,
	output logic [31:0] word_lane_3,
	output logic        block_end
);
	import bp128_pkg::*;

	logic [BW_W-1:0] bit_width_q;
	logic            cfg_wr;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	lane_vec_t       lanes;
	lane_vec_t       words;
	bp128_entry_t    push_entry;
	bp128_entry_t    head;

	// config: only register 0 exists; writes elsewhere are dropped
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_BIT_WIDTH) ? {{(32-BW_W){1'b0}}, bit_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q <= FULL_WIDTH;
		end else if (cfg_wr && (paddr[2] == REG_BIT_WIDTH)) begin
			bit_width_q <= pwdata[BW_W-1:0];
		end
	end

	assign lanes[0] = lane_0;
	assign lanes[1] = lane_1;
	assign lanes[2] = lane_2;
	assign lanes[3] = lane_3;

	assign word_lane_0 = words[0];
	assign word_lane_1 = words[1];
	assign word_lane_2 = words[2];
	assign word_lane_3 = words[3];

	// front: mask, offset and word-complete/spill flags per request
	bp128_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_width  (bit_width_q),
		.item_valid (item_valid),
		.lanes      (lanes),
		.q_full     (q_full),
		.item_ready (item_ready),
		.push       (push),
		.entry      (push_entry)
	);

	bp128_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	// back: accumulate per lane; non-emitting requests retire without output space
	bp128_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head),
		.word_ready (word_ready),
		.pop        (pop),
		.word_valid (word_valid),
		.words      (words),
		.block_end  (block_end)
	);

	// with a nonzero width, the last request of a block always closes a word exactly, with no spill
	`BP_ASSERT(a_last_closes_word, (push && push_entry.last && (bit_width_q != '0)) |-> (push_entry.emit && !push_entry.spill), "last request did not close a word")
	// a retired emitting request must show up in the output register
	`BP_ASSERT_NEXT(a_emit_reaches_out, (pop && head.emit), word_valid, "emitted word lost")
	// config write lands in the width register
	`BP_ASSERT_NEXT(a_cfg_write, (cfg_wr && (paddr[2] == REG_BIT_WIDTH)), (bit_width_q == $past(pwdata[BW_W-1:0])), "bit_width write lost")

endmodule

### dv/bp128_checker.sv
// Request/word monitor for the bit packer: tracks B, predicts packed words, compares.
`timescale 1ns / 1ps

module bp128_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              item_valid,
	input  logic              item_ready,
	input  bp128_pkg::word_t  lane_0,
	input  bp128_pkg::word_t  lane_1,
	input  bp128_pkg::word_t  lane_2,
	input  bp128_pkg::word_t  lane_3,
	input  logic              word_valid,
	input  logic              word_ready,
	input  bp128_pkg::word_t  word_lane_0,
	input  bp128_pkg::word_t  word_lane_1,
	input  bp128_pkg::word_t  word_lane_2,
	input  bp128_pkg::word_t  word_lane_3,
	input  logic              block_end,
	output int                mismatch_count,
	output int                words_due
);
	import bp128_pkg::*;

	typedef struct {
		lane_vec_t lanes;
		logic      last;
	} packed_word_t;

	packed_word_t     packed_words_q[$];
	logic [BW_W-1:0]  width_reg;
	word_t            lane_acc [LANE_COUNT];
	logic [POS_W-1:0] block_pos;

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// masks each lane to B bits and ORs it in at offset (pos*B) mod 32
	task automatic pack_request(lane_vec_t vals);
		int unsigned  b;
		int unsigned  sh;
		int           k;
		word_t        mask;
		word_t        v;
		word_t        acc;
		logic         emit;
		logic         spill;
		packed_word_t w;
		b = (width_reg > FULL_WIDTH) ? WORD_W : width_reg;
		mask = (b >= WORD_W) ? '1 : ((word_t'(1) << b) - 1);
		sh = (block_pos * b) % WORD_W;
		emit = (b != 0) && (sh + b >= WORD_W);
		spill = (b != 0) && (sh + b > WORD_W);
		w.last = (block_pos == POS_W'(ITEMS_PER_BLOCK - 1));
		for (k = 0; k < LANE_COUNT; k++) begin
			v = vals[k] & mask;
			acc = (sh == 0) ? v : (lane_acc[k] | (v << sh));
			w.lanes[k] = acc;
			// spill only with a nonzero offset
			if (spill)
				acc = v >> (WORD_W - sh);
			lane_acc[k] = acc;
		end
		block_pos = block_pos + 1'b1;
		if (emit)
			packed_words_q.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		lane_vec_t    got;
		packed_word_t want;
		int           k;
		if (!arst_n) begin
			width_reg = FULL_WIDTH;
			for (k = 0; k < LANE_COUNT; k++)
				lane_acc[k] = '0;
			block_pos = '0;
			packed_words_q.delete();
			mismatch_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_WIDTH)
				width_reg = pwdata[BW_W-1:0];
			if (item_valid && item_ready)
				pack_request({lane_3, lane_2, lane_1, lane_0});
			if (word_valid && word_ready) begin
				got = {word_lane_3, word_lane_2, word_lane_1, word_lane_0};
				if (packed_words_q.size() == 0) begin
					report_mismatch("word with none due", word_lane_0, '0);
				end else begin
					want = packed_words_q.pop_front();
					for (k = 0; k < LANE_COUNT; k++)
						if (got[k] !== want.lanes[k])
							report_mismatch($sformatf("word_lane_%0d", k), got[k],
								want.lanes[k]);
					if (block_end !== want.last)
						report_mismatch("block_end", word_t'(block_end), word_t'(want.last));
				end
			end
		end
		words_due = packed_words_q.size();
	end

endmodule

### dv/testbench.sv
// Top of the bit packer bench: clock, reset, width writes, request and word traffic, verdict.
`timescale 1ns / 1ps

module testbench;
	import bp128_pkg::*;

	localparam int RANDOM_REQUESTS = 1850;
	localparam int HOLD_OFF_CYCLES = 200;   // long output stall, fills the queue
	localparam int DRAIN_CYCLES    = 16;    // queue depth + latency, with margin
	localparam int TAIL_CYCLES     = 20;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	word_t       lane_0;
	word_t       lane_1;
	word_t       lane_2;
	word_t       lane_3;
	logic        word_valid;
	logic        word_ready;
	word_t       word_lane_0;
	word_t       word_lane_1;
	word_t       word_lane_2;
	word_t       word_lane_3;
	logic        block_end;

	int          mismatch_count;
	int          words_due;

	int          req_pos;        // position of the next request within its block
	int unsigned cur_eff_width;  // B as the block sees it, saturated to 32
	bit          hold_off_req;
	bit          hold_off_done;

	bit_pack_128 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.lane_0      (lane_0),
		.lane_1      (lane_1),
		.lane_2      (lane_2),
		.lane_3      (lane_3),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.word_lane_0 (word_lane_0),
		.word_lane_1 (word_lane_1),
		.word_lane_2 (word_lane_2),
		.word_lane_3 (word_lane_3),
		.block_end   (block_end)
	);

	bp128_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.lane_0         (lane_0),
		.lane_1         (lane_1),
		.lane_2         (lane_2),
		.lane_3         (lane_3),
		.word_valid     (word_valid),
		.word_ready     (word_ready),
		.word_lane_0    (word_lane_0),
		.word_lane_1    (word_lane_1),
		.word_lane_2    (word_lane_2),
		.word_lane_3    (word_lane_3),
		.block_end      (block_end),
		.mismatch_count (mismatch_count),
		.words_due      (words_due)
	);

	// 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// B mix: extremes weighted up, saturating codes 33..63 included
	function automatic logic [BW_W-1:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return FULL_WIDTH;
		if (r < 30)
			return BW_W'(1);
		if (r < 38)
			return BW_W'(31);
		if (r < 45)
			return BW_W'($urandom_range(33, 63));
		return BW_W'($urandom_range(2, 30));
	endfunction

	// lane values: full random, fitting in B, all ones, zero, one hot
	function automatic lane_vec_t rand_request(int unsigned b);
		lane_vec_t   vals;
		word_t       mask;
		int unsigned r;
		int          k;
		mask = (b >= WORD_W) ? '1 : ((word_t'(1) << b) - 1);
		for (k = 0; k < LANE_COUNT; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				vals[k] = $urandom;
			else if (r < 70)
				vals[k] = $urandom & mask;
			else if (r < 80)
				vals[k] = '1;
			else if (r < 90)
				vals[k] = '0;
			else
				vals[k] = word_t'(1) << $urandom_range(0, 31);
		end
		return vals;
	endfunction

	// offer one request after a gap, hold it until accepted
	task automatic drive_request(lane_vec_t vals, int gap);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		lane_0     <= vals[0];
		lane_1     <= vals[1];
		lane_2     <= vals[2];
		lane_3     <= vals[3];
		do @(posedge clk); while (!item_ready);
		req_pos = (req_pos + 1) % ITEMS_PER_BLOCK;
	endtask

	// write B only with the block idle: all words out, then a drain for
	// requests still in flight that complete no word
	task automatic set_bit_width(logic [BW_W-1:0] b);
		@(negedge clk);
		item_valid <= 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		// setup
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_BIT_WIDTH, 2'b00};
		pwdata  <= {26'($urandom), b};   // upper bits are don't-care
		@(negedge clk);
		// access
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_eff_width = (b > FULL_WIDTH) ? WORD_W : b;
	endtask

	// word receiver: random stalls, calm stretches, and one long hold-off
	// on request of the stimulus while requests keep coming
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left  = 0;
		word_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				word_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (calm_left > 0) begin
				calm_left--;
				word_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				word_ready <= 1'b0;
			end else begin
				word_ready <= 1'b1;
				if ($urandom_range(0, 99) < 2)
					calm_left = $urandom_range(50, 150);
				else
					stall_left = pick_gap();
			end
		end
	end

	// stimulus and verdict
	initial begin
		int          n;
		int          phase;
		int          random_sent;
		bit          no_idle;
		logic [BW_W-1:0] b;

		// every input known from time zero
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_valid    = 1'b0;
		lane_0        = '0;
		lane_1        = '0;
		lane_2        = '0;
		lane_3        = '0;
		req_pos       = 0;
		cur_eff_width = WORD_W;
		hold_off_req  = 1'b0;
		hold_off_done = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: full width out of reset, every request is its own word
		drive_request('0, 0);
		drive_request('1, 0);
		drive_request({32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555}, 0);
		drive_request({32'hfffffffe, 32'h7fffffff, 32'h00000001, 32'h80000000}, 1);
		// zero width: position moves on, nothing comes out
		set_bit_width('0);
		repeat (3) drive_request(rand_request(WORD_W), pick_gap());
		// codes above 32 saturate to full width
		set_bit_width(BW_W'(63));
		drive_request('1, 0);
		drive_request(rand_request(WORD_W), 0);
		set_bit_width(BW_W'(33));
		drive_request(rand_request(WORD_W), 0);
		// width changes mid-block: odd offsets, spill-over across words
		set_bit_width(BW_W'(7));
		repeat (5) drive_request(rand_request(cur_eff_width), pick_gap());
		set_bit_width(BW_W'(1));
		repeat (3) drive_request(rand_request(cur_eff_width), 0);

		// random phases: mostly whole blocks at one B, sometimes a cut block
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_REQUESTS) begin
			b = (phase == 0) ? FULL_WIDTH : pick_width();
			set_bit_width(b);
			// first phase: output held off, one word per request fills the queue
			if (phase == 0)
				hold_off_req = 1'b1;
			no_idle = (phase == 0) || ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, 40);
			else
				n = (ITEMS_PER_BLOCK - req_pos) % ITEMS_PER_BLOCK
					+ ITEMS_PER_BLOCK * $urandom_range(1, 2);
			repeat (n)
				drive_request(rand_request(cur_eff_width), no_idle ? 0 : pick_gap());
			random_sent += n;
			phase++;
		end

		// drain, then a tail to catch stray words
		@(negedge clk);
		item_valid <= 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && words_due == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
